/* hw/rtl/mva_pkg.sv */
// shared types, widths and constants of the matrix-vector accumulate block
// no dependencies; imported by every module of the block
`default_nettype none

package mva_pkg;

   // field widths
   localparam int COLUMN_W  = 10;
   localparam int DATA_W    = 32;
   localparam int ACC_W     = 48;
   localparam int COLS_W    = 11;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // multiplier operand and product widths
   localparam int MUL_IN_W  = 33;
   localparam int PROD_W    = 64;
   // exact row sum before clipping
   localparam int SUM_W     = 67;

   // default vector store depth
   localparam int MAX_COLS_DEF = 1024;
   // largest number of columns a row can span
   localparam int COLS_CAP = 1024;

   // register indexes
   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_BETA  = 2'd1;
   localparam logic [1:0] REG_COLS  = 2'd2;

   // register reset values
   localparam logic [DATA_W-1:0] ALPHA_RST = 32'd1507;
   localparam logic [DATA_W-1:0] BETA_RST  = 32'd2949;
   localparam logic [COLS_W-1:0] COLS_RST  = 11'd1024;

   // request action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_MATRIX = 1'b1;

   // configuration seen by the datapath
   typedef struct packed {
      logic [DATA_W-1:0] alpha;
      logic [DATA_W-1:0] beta;
      logic [COLS_W-1:0] cols;
   } cfg_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_H,
      ST_MUL_L,
      ST_ACC,
      ST_EMIT
   } state_type;

   // operand choice of the shared multiplier
   typedef enum logic [1:0] {
      OP_NONE,
      OP_GAIN,
      OP_HIGH,
      OP_LOW
   } mul_op_type;

endpackage

`default_nettype wire

/* hw/rtl/matrix_vector_accumulate.sv */
// matrix-vector accumulate: a vector beat leaves the request channel ready for the next beat;
// a matrix beat stalls it through three shared 33x33 multiplier passes and the accumulate step.
// the accumulate step of a row's last matrix beat loads the finished row into the response register;
// requests go on while it waits on rsp_stall, but a second row stalls them until it leaves.
// synchronous active-high reset clears the sequencer, row value, clip flag and
// registers; the vector store is not cleared and holds garbage until written.
`default_nettype none

module matrix_vector_accumulate
   import mva_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [COLUMN_W-1:0]   req_column,
   input  wire logic [DATA_W-1:0]     req_value,
   input  wire logic [DATA_W-1:0]     req_w_start,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [ACC_W-1:0]      rsp_row_value,
   output logic                       rsp_saturated,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int ADDR_W   = $clog2(MAX_COLS);
   localparam int CMP_W    = ((ADDR_W > COLUMN_W) ? ADDR_W : COLUMN_W) + 1;
   localparam int LIMIT    = (MAX_COLS < COLS_CAP) ? MAX_COLS : COLS_CAP;
   localparam logic [COLS_W-1:0] LAST_MAX = COLS_W'(LIMIT - 1);

   cfg_type           cfg;
   state_type         state_ff, state_in;
   mul_op_type        mul_op;

   logic              req_beat;
   logic              load_beat;
   logic              mat_beat;
   logic [CMP_W-1:0]  col_ext;
   logic              col_in_range;
   logic [ADDR_W-1:0] col_addr;
   logic [COLS_W-1:0] last_col;

   // item registers
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] w_start_ff;
   logic              first_ff;
   logic              emit_ff;
   logic              x_zero_ff;
   logic [15:0]       ql_ff;
   logic [PROD_W-1:0] hi_ff;

   logic [DATA_W-1:0]   rd_data;
   logic [DATA_W-1:0]   x_val;
   logic [MUL_IN_W-1:0] op_a;
   logic [MUL_IN_W-1:0] op_b;
   logic [PROD_W-1:0]   prod;

   // row state
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             clip_ff, clip_in;
   logic [SUM_W-1:0] base_ext;
   logic [SUM_W-1:0] sum;
   logic             sum_ovf;
   logic [ACC_W-1:0] sum_clip;

   // response register
   logic             out_valid_ff, out_valid_in;
   logic [ACC_W-1:0] out_value_ff;
   logic             out_sat_ff;
   logic             out_free;
   logic             out_load;
   logic             out_from_sum;

   mva_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // request decode
   assign req_beat     = req_valid & ~req_stall;
   assign load_beat    = req_beat & (req_action == ACT_LOAD);
   assign mat_beat     = req_beat & (req_action == ACT_MATRIX);
   assign col_ext      = CMP_W'(req_column);
   assign col_in_range = col_ext < CMP_W'(MAX_COLS);
   assign col_addr     = col_ext[ADDR_W-1:0];

   mva_xmem #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (ADDR_W)
   ) u_xmem (
      .clock   (clock),
      .wr_en   (load_beat & col_in_range),
      .wr_addr (col_addr),
      .wr_data (req_value),
      .rd_en   (mat_beat),
      .rd_addr (col_addr),
      .rd_data (rd_data)
   );

   // last column of a row, clamped to the usable range
   always_comb begin
      priority if (cfg.cols == '0) begin
         last_col = '0;
      end else if (cfg.cols > LAST_MAX) begin
         last_col = LAST_MAX;
      end else begin
         last_col = cfg.cols - COLS_W'(1);
      end
   end

   // capture a matrix beat
   always_ff @(posedge clock) begin
      if (mat_beat) begin
         value_ff   <= req_value;
         w_start_ff <= req_w_start;
         first_ff   <= (req_column == '0);
         emit_ff    <= (req_column == last_col[COLUMN_W-1:0]);
         x_zero_ff  <= ~col_in_range;
      end
   end

   assign x_val = x_zero_ff ? '0 : rd_data;

   // shared multiplier operands
   always_comb begin
      unique case (mul_op)
         OP_GAIN: begin
            op_a = {cfg.alpha[DATA_W-1], cfg.alpha};
            op_b = {value_ff[DATA_W-1], value_ff};
         end
         OP_HIGH: begin
            op_a = {prod[PROD_W-1], prod[PROD_W-1:32]};
            op_b = {x_val[DATA_W-1], x_val};
         end
         OP_LOW: begin
            op_a = {17'd0, ql_ff};
            op_b = {x_val[DATA_W-1], x_val};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   mva_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // hold the partial terms of the long product
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL_H) begin
         ql_ff <= prod[31:16];
      end
      if (state_ff == ST_MUL_L) begin
         hi_ff <= prod;
      end
   end

   // row sum: base - beta + high term + floor(low term / 2^16)
   assign base_ext = first_ff ? {{(SUM_W-DATA_W){w_start_ff[DATA_W-1]}}, w_start_ff}
                              : {{(SUM_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff};
   assign sum = base_ext
              - {{(SUM_W-DATA_W){cfg.beta[DATA_W-1]}}, cfg.beta}
              + {{(SUM_W-PROD_W){hi_ff[PROD_W-1]}}, hi_ff}
              + {{(SUM_W-48){prod[PROD_W-1]}}, prod[PROD_W-1:16]};

   // saturate to the accumulator width
   assign sum_ovf  = (sum[SUM_W-1:ACC_W-1] != '0) && (sum[SUM_W-1:ACC_W-1] != '1);
   assign sum_clip = sum_ovf ? {sum[SUM_W-1], {(ACC_W-1){~sum[SUM_W-1]}}}
                             : sum[ACC_W-1:0];

   always_comb begin
      acc_in  = acc_ff;
      clip_in = clip_ff;
      if (state_ff == ST_ACC) begin
         acc_in  = sum_clip;
         clip_in = (clip_ff & ~first_ff) | sum_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         clip_ff <= clip_in;
      end
   end

   assign out_free = ~out_valid_ff | ~rsp_stall;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (mat_beat) state_in = ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_H;
         ST_MUL_H: state_in = ST_MUL_L;
         ST_MUL_L: state_in = ST_ACC;
         ST_ACC: begin
            priority if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mul_op       = OP_NONE;
      req_stall    = 1'b1;
      out_load     = 1'b0;
      out_from_sum = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_MUL_P: mul_op = OP_GAIN;
         ST_MUL_H: mul_op = OP_HIGH;
         ST_MUL_L: mul_op = OP_LOW;
         ST_ACC: begin
            out_load     = emit_ff & out_free;
            out_from_sum = 1'b1;
         end
         ST_EMIT:  out_load = out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff <= out_from_sum ? acc_in : acc_ff;
         out_sat_ff   <= out_from_sum ? clip_in : clip_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

`default_nettype wire

/* hw/rtl/mva_csr.sv */
// configuration registers behind the apb-style port
// depends on mva_pkg for register indexes, reset values and cfg_type
`default_nettype none

module mva_csr
   import mva_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic [DATA_W-1:0] alpha_ff, alpha_in;
   logic [DATA_W-1:0] beta_ff, beta_in;
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register write decode
   always_comb begin
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      cols_in  = cols_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ALPHA: alpha_in = csr_pwdata;
            REG_BETA:  beta_in  = csr_pwdata;
            REG_COLS:  cols_in  = csr_pwdata[COLS_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RST;
         beta_ff  <= BETA_RST;
         cols_ff  <= COLS_RST;
      end else begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
         cols_ff  <= cols_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_ALPHA: csr_prdata = alpha_ff;
         REG_BETA:  csr_prdata = beta_ff;
         REG_COLS:  csr_prdata = CSR_DATA_W'(cols_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign cfg = '{alpha: alpha_ff, beta: beta_ff, cols: cols_ff};

endmodule

`default_nettype wire

/* hw/rtl/mva_xmem.sv */
// vector store: one write port, one registered read port
// depends on mva_pkg for the data width
`default_nettype none

module mva_xmem
   import mva_pkg::*;
#(
   parameter int DEPTH  = MAX_COLS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
)(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/mva_mul.sv */
// shared signed multiplier with a registered product
// depends on mva_pkg for operand and product widths
`default_nettype none

module mva_mul
   import mva_pkg::*;
(
   input  wire logic                clock,
   input  wire logic [MUL_IN_W-1:0] op_a,
   input  wire logic [MUL_IN_W-1:0] op_b,
   output logic      [PROD_W-1:0]   prod
);

   logic signed [2*MUL_IN_W-1:0] full;
   logic        [PROD_W-1:0]     prod_ff;

   // every product used here fits in the low bits
   assign full = $signed(op_a) * $signed(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= full[PROD_W-1:0];
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* hw/rtl/mva_checker.sv */
// port-level checks of the matrix-vector accumulate block, bound to the top level
// depends on mva_pkg for widths and action codes
`default_nettype none

module mva_checker
   import mva_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              req_action,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [ACC_W-1:0]  rsp_row_value,
   input wire logic              rsp_saturated
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_row_value) && $stable(rsp_saturated))
      else $error("rsp payload changed while stalled");

   // a matrix beat stalls the request channel while it is in work in the shared multiplier and accumulate step
   a_matrix_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_MATRIX)
      |=> req_stall ##1 req_stall ##1 req_stall ##1 req_stall)
      else $error("request taken while a matrix beat is in work");

   // a vector beat leaves the block ready for the next beat
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_LOAD) |=> !req_stall)
      else $error("vector beat stalled the request channel");

endmodule

bind matrix_vector_accumulate mva_checker u_mva_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_value (rsp_row_value),
   .rsp_saturated (rsp_saturated)
);

`default_nettype wire
